// ===== rtl/core/assert_macros.svh =====
// assertion macros for the vertex transform core
// clocked on clock, disabled while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle
`define VRSP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define VRSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/vrsp_pkg.sv =====
// constants, register codes and the sine table for the vertex transform core
// no dependencies
`timescale 1ns / 1ps

package vrsp_pkg;

   localparam int TABLE_ENTRIES   = 512;
   localparam int ANGLE_W         = $clog2(TABLE_ENTRIES);
   localparam int HALF_ENTRIES    = TABLE_ENTRIES / 2;
   localparam int COORD_FRAC_BITS = 16;
   localparam int SINE_W          = 16;
   localparam int SINE_FRAC       = 14;
   localparam int COORD_W         = 32;
   localparam int FOCAL_W         = 16;
   localparam int CSR_IDX_W       = 3;

   localparam longint unsigned PI_Q28 = 64'd843314857;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WORLD_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WORLD_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WORLD_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_EYE     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_FOCAL   = 3'd7;

   // reset values
   localparam logic [ANGLE_W-1:0] ANGLE_X_RESET = ANGLE_W'(1);
   localparam logic [ANGLE_W-1:0] ANGLE_Y_RESET = ANGLE_W'(2);
   localparam logic [ANGLE_W-1:0] ANGLE_Z_RESET = ANGLE_W'(3);
   localparam logic [COORD_W-1:0] WORLD_Z_RESET = COORD_W'(100 << COORD_FRAC_BITS);
   localparam logic [COORD_W-1:0] EYE_RESET     = COORD_W'(10 << COORD_FRAC_BITS);
   localparam logic [FOCAL_W-1:0] FOCAL_RESET   = FOCAL_W'(1024);

   localparam logic [COORD_W-1:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

   localparam int HALF_TABLE_W = (HALF_ENTRIES + 1) * SINE_W;

   // taylor series in q28 with truncating steps, rounded to q1.14
   function automatic logic [SINE_W-1:0] sine_sample(int unsigned j);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      x    = (PI_Q28 * 64'd2 * 64'(j)) / TABLE_ENTRIES;
      x2   = (x * x) >> 28;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 12; k++) begin
         term = ((term * x2) >> 28) / 64'((2 * k) * (2 * k + 1));
         if ((k & 1) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      sum = (sum + 8192) >>> SINE_FRAC;
      return SINE_W'(sum);
   endfunction

   function automatic logic [HALF_TABLE_W-1:0] build_half_table();
      logic [HALF_TABLE_W-1:0] t;
      t = '0;
      for (int i = 0; i <= HALF_ENTRIES; i++) begin
         t[i*SINE_W +: SINE_W] = sine_sample(i);
      end
      return t;
   endfunction

   // first half turn, inclusive of the half-turn sample
   localparam logic [HALF_TABLE_W-1:0] HALF_TABLE = build_half_table();

   // second half of the turn mirrors the first with the sign flipped
   function automatic logic [SINE_W-1:0] sine_lookup(logic [ANGLE_W-1:0] a);
      logic               neg;
      logic [ANGLE_W-1:0] j;
      logic [SINE_W-1:0]  v;
      neg = (a > ANGLE_W'(HALF_ENTRIES));
      j   = neg ? (ANGLE_W'(0) - a) : a;
      v   = HALF_TABLE[j*SINE_W +: SINE_W];
      return neg ? (SINE_W'(0) - v) : v;
   endfunction

   function automatic logic [SINE_W-1:0] cosine_lookup(logic [ANGLE_W-1:0] a);
      return sine_lookup(a + ANGLE_W'(TABLE_ENTRIES / 4));
   endfunction

endpackage

// ===== rtl/core/vertex_rotate_stereo_project.sv =====
// vertex rotate and stereo projection core: rotation, translation, divide, focal scale
// depends on vrsp_pkg and assert_macros.svh
`timescale 1ns / 1ps
//
// Usage
//   req channel: one vertex word (req_in_x/y/z, signed q16.16) moves when req_valid
//   is high and req_stall is low. rsp channel: one result word moves when rsp_valid
//   is high and rsp_stall is low: rotated vertex, left and right eye screen
//   coordinates, a zero-depth flag and a saturation flag. csr port: registers are
//   written with csr_we, csr_index and csr_wdata; write only while no word is in
//   flight, unchecked by the block. Angle writes look up sine and cosine at once.
// Timing
//   a word passes 61 registers from the accepting edge to rsp_valid: six rotation
//   stages (multiply, then add and round, per axis), translate, divide setup,
//   50 restoring divide stages of one quotient bit each, sign fix, focal multiply
//   and the output register. A new word is taken every cycle req_stall is low.
// Reset and stall
//   reset clears every valid bit and loads the register defaults. While the
//   output word is held by rsp_stall the whole pipeline freezes and req_stall
//   is raised in the same cycle; nothing is dropped or repeated.
//
module vertex_rotate_stereo_project
   import vrsp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [COORD_W-1:0]   req_in_x,
   input  logic [COORD_W-1:0]   req_in_y,
   input  logic [COORD_W-1:0]   req_in_z,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [COORD_W-1:0]   rsp_rot_x,
   output logic [COORD_W-1:0]   rsp_rot_y,
   output logic [COORD_W-1:0]   rsp_rot_z,
   output logic [COORD_W-1:0]   rsp_left_x,
   output logic [COORD_W-1:0]   rsp_left_y,
   output logic [COORD_W-1:0]   rsp_right_x,
   output logic [COORD_W-1:0]   rsp_right_y,
   output logic                 rsp_depth_was_zero,
   output logic                 rsp_saturated,

   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata
);

`include "assert_macros.svh"

   localparam int LANES     = 3;
   localparam int PROD_W    = COORD_W + SINE_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int CLIP_W    = SUM_W - SINE_FRAC;
   localparam int DEN_W     = COORD_W + 1;
   localparam int MAG_W     = COORD_W + 2;
   localparam int REM_W     = COORD_W;
   localparam int NUM_W     = MAG_W + COORD_FRAC_BITS;
   localparam int DIV_STEPS = NUM_W;
   localparam int LIM_BIT   = 40;
   localparam int QS_W      = LIM_BIT + 2;
   localparam int FPROD_W   = QS_W + FOCAL_W;

   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (SINE_FRAC - 1));

   typedef struct packed {
      logic [COORD_W-1:0] val;
      logic               ovf;
   } sat_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] p0;
      logic signed [PROD_W-1:0] p1;
      logic signed [PROD_W-1:0] p2;
      logic signed [PROD_W-1:0] p3;
      logic [COORD_W-1:0]       pass;
      logic                     sat;
   } mul_type;

   typedef struct packed {
      logic [COORD_W-1:0] a;
      logic [COORD_W-1:0] b;
      logic               ovf;
   } pair_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               sat;
   } vec_type;

   typedef struct packed {
      vec_type            v;
      logic [DEN_W-1:0]   tx;
      logic [DEN_W-1:0]   ty;
      logic [MAG_W-1:0]   tr;
      logic [DEN_W-1:0]   tz;
   } trans_type;

   typedef struct packed {
      vec_type                        v;
      logic                           zero;
      logic [DEN_W-1:0]               den;
      logic [LANES-1:0]               neg;
      logic [LANES-1:0][REM_W-1:0]    rem;
      logic [LANES-1:0][NUM_W-1:0]    nq;
   } div_type;

   typedef struct packed {
      vec_type                        v;
      logic                           zero;
      logic [LANES-1:0]               neg;
      logic [LANES-1:0]               big;
      logic [LANES-1:0][QS_W-1:0]     qs;
   } quo_type;

   typedef struct packed {
      vec_type                        v;
      logic                           zero;
      logic [LANES-1:0]               neg;
      logic [LANES-1:0]               big;
      logic [LANES-1:0][FPROD_W-1:0]  prod;
   } fprod_type;

   function automatic sat_type clip_rot(logic [CLIP_W-1:0] v);
      sat_type r;
      r.ovf = !((&v[CLIP_W-1:COORD_W-1]) || !(|v[CLIP_W-1:COORD_W-1]));
      r.val = r.ovf ? (v[CLIP_W-1] ? SAT_MIN : SAT_MAX) : v[COORD_W-1:0];
      return r;
   endfunction

   function automatic sat_type clip_proj(logic [FPROD_W-1:0] v);
      sat_type r;
      r.ovf = !((&v[FPROD_W-1:COORD_W-1]) || !(|v[FPROD_W-1:COORD_W-1]));
      r.val = r.ovf ? (v[FPROD_W-1] ? SAT_MIN : SAT_MAX) : v[COORD_W-1:0];
      return r;
   endfunction

   // a*c, b*s, a*s, b*c for one axis
   function automatic mul_type rot_mul(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
                                       logic [SINE_W-1:0] c, logic [SINE_W-1:0] s,
                                       logic [COORD_W-1:0] pass, logic sat);
      mul_type m;
      m.p0   = $signed(a) * $signed(c);
      m.p1   = $signed(b) * $signed(s);
      m.p2   = $signed(a) * $signed(s);
      m.p3   = $signed(b) * $signed(c);
      m.pass = pass;
      m.sat  = sat;
      return m;
   endfunction

   // round half up with floor shift, then clip
   function automatic pair_type rot_add(mul_type m);
      logic [SUM_W-1:0] sa;
      logic [SUM_W-1:0] sb;
      sat_type          ca;
      sat_type          cb;
      pair_type         r;
      sa    = {m.p0[PROD_W-1], m.p0} - {m.p1[PROD_W-1], m.p1} + ROUND_HALF;
      sb    = {m.p2[PROD_W-1], m.p2} + {m.p3[PROD_W-1], m.p3} + ROUND_HALF;
      ca    = clip_rot(sa[SUM_W-1:SINE_FRAC]);
      cb    = clip_rot(sb[SUM_W-1:SINE_FRAC]);
      r.a   = ca.val;
      r.b   = cb.val;
      r.ovf = ca.ovf | cb.ovf;
      return r;
   endfunction

   // ---------------- configuration ----------------
   logic [SINE_W-1:0]  sin_x_ff, cos_x_ff, sin_y_ff, cos_y_ff, sin_z_ff, cos_z_ff;
   logic [COORD_W-1:0] world_x_ff, world_y_ff, world_z_ff, eye_ff;
   logic [FOCAL_W-1:0] focal_ff;
   logic [SINE_W-1:0]  csr_sin, csr_cos;

   always_comb begin
      csr_sin = sine_lookup(csr_wdata[ANGLE_W-1:0]);
      csr_cos = cosine_lookup(csr_wdata[ANGLE_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sin_x_ff   <= sine_lookup(ANGLE_X_RESET);
         cos_x_ff   <= cosine_lookup(ANGLE_X_RESET);
         sin_y_ff   <= sine_lookup(ANGLE_Y_RESET);
         cos_y_ff   <= cosine_lookup(ANGLE_Y_RESET);
         sin_z_ff   <= sine_lookup(ANGLE_Z_RESET);
         cos_z_ff   <= cosine_lookup(ANGLE_Z_RESET);
         world_x_ff <= '0;
         world_y_ff <= '0;
         world_z_ff <= WORLD_Z_RESET;
         eye_ff     <= EYE_RESET;
         focal_ff   <= FOCAL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_ANGLE_X: begin
               sin_x_ff <= csr_sin;
               cos_x_ff <= csr_cos;
            end
            REG_ANGLE_Y: begin
               sin_y_ff <= csr_sin;
               cos_y_ff <= csr_cos;
            end
            REG_ANGLE_Z: begin
               sin_z_ff <= csr_sin;
               cos_z_ff <= csr_cos;
            end
            REG_WORLD_X: world_x_ff <= csr_wdata;
            REG_WORLD_Y: world_y_ff <= csr_wdata;
            REG_WORLD_Z: world_z_ff <= csr_wdata;
            REG_EYE:     eye_ff     <= csr_wdata;
            REG_FOCAL:   focal_ff   <= csr_wdata[FOCAL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ---------------- rotation ----------------
   mul_type   m1_ff, m1_in, m3_ff, m3_in, m5_ff, m5_in;
   vec_type   a2_ff, a2_in, a4_ff, a4_in, a6_ff, a6_in;
   pair_type  pr2, pr4, pr6;
   logic      m1_v_ff, a2_v_ff, m3_v_ff, a4_v_ff, m5_v_ff, a6_v_ff;

   always_comb begin
      // about x: (y, z)
      m1_in    = rot_mul(req_in_y, req_in_z, cos_x_ff, sin_x_ff, req_in_x, 1'b0);
      pr2      = rot_add(m1_ff);
      a2_in.x  = m1_ff.pass;
      a2_in.y  = pr2.a;
      a2_in.z  = pr2.b;
      a2_in.sat = m1_ff.sat | pr2.ovf;
      // about y: (x, z)
      m3_in    = rot_mul(a2_ff.x, a2_ff.z, cos_y_ff, sin_y_ff, a2_ff.y, a2_ff.sat);
      pr4      = rot_add(m3_ff);
      a4_in.x  = pr4.a;
      a4_in.y  = m3_ff.pass;
      a4_in.z  = pr4.b;
      a4_in.sat = m3_ff.sat | pr4.ovf;
      // about z: (x, y)
      m5_in    = rot_mul(a4_ff.x, a4_ff.y, cos_z_ff, sin_z_ff, a4_ff.z, a4_ff.sat);
      pr6      = rot_add(m5_ff);
      a6_in.x  = pr6.a;
      a6_in.y  = pr6.b;
      a6_in.z  = m5_ff.pass;
      a6_in.sat = m5_ff.sat | pr6.ovf;
   end

   // ---------------- translate ----------------
   trans_type t7_ff, t7_in;
   logic      t7_v_ff;

   always_comb begin
      t7_in.v  = a6_ff;
      t7_in.tx = {a6_ff.x[COORD_W-1], a6_ff.x} + {world_x_ff[COORD_W-1], world_x_ff};
      t7_in.ty = {a6_ff.y[COORD_W-1], a6_ff.y} + {world_y_ff[COORD_W-1], world_y_ff};
      t7_in.tz = {a6_ff.z[COORD_W-1], a6_ff.z} + {world_z_ff[COORD_W-1], world_z_ff};
      // right eye numerator: x + world_x - eye_offset
      t7_in.tr = {{2{a6_ff.x[COORD_W-1]}}, a6_ff.x}
               + {{2{world_x_ff[COORD_W-1]}}, world_x_ff}
               - {{2{eye_ff[COORD_W-1]}}, eye_ff};
   end

   // ---------------- divide ----------------
   div_type              dv_ff [0:DIV_STEPS];
   div_type              dv_in [0:DIV_STEPS];
   logic [DIV_STEPS:0]   dv_v_ff;
   logic [DEN_W-1:0]     depth;
   logic [LANES-1:0][MAG_W-1:0] num;
   logic [MAG_W-1:0]     mag;

   // setup: zero depth becomes 1.0, then magnitudes and quotient signs
   always_comb begin
      dv_in[0].v    = t7_ff.v;
      dv_in[0].zero = (t7_ff.tz == '0);
      depth         = dv_in[0].zero ? DEN_W'(1 << COORD_FRAC_BITS) : t7_ff.tz;
      dv_in[0].den  = depth[DEN_W-1] ? (DEN_W'(0) - depth) : depth;
      num[0]        = {t7_ff.tx[DEN_W-1], t7_ff.tx};
      num[1]        = {t7_ff.ty[DEN_W-1], t7_ff.ty};
      num[2]        = t7_ff.tr;
      for (int l = 0; l < LANES; l++) begin
         mag              = num[l][MAG_W-1] ? (MAG_W'(0) - num[l]) : num[l];
         dv_in[0].neg[l]  = num[l][MAG_W-1] ^ depth[DEN_W-1];
         dv_in[0].rem[l]  = '0;
         dv_in[0].nq[l]   = {mag, COORD_FRAC_BITS'(0)};
      end
   end

   // one quotient bit per stage; the dividend shifts out as quotient bits shift in
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [REM_W:0] trial;
      logic           ge;
      always_comb begin
         dv_in[k+1] = dv_ff[k];
         for (int l = 0; l < LANES; l++) begin
            trial = {dv_ff[k].rem[l], dv_ff[k].nq[l][NUM_W-1]};
            ge    = (trial >= dv_ff[k].den);
            dv_in[k+1].rem[l] = ge ? REM_W'(trial - dv_ff[k].den) : trial[REM_W-1:0];
            dv_in[k+1].nq[l]  = {dv_ff[k].nq[l][NUM_W-2:0], ge};
         end
      end
   end

   // ---------------- sign and range ----------------
   quo_type q_ff, q_in;
   logic    q_v_ff;
   logic [NUM_W-1:0] qmag;

   always_comb begin
      q_in.v    = dv_ff[DIV_STEPS].v;
      q_in.zero = dv_ff[DIV_STEPS].zero;
      q_in.neg  = dv_ff[DIV_STEPS].neg;
      for (int l = 0; l < LANES; l++) begin
         qmag         = dv_ff[DIV_STEPS].nq[l];
         // magnitude above 2^40 clips unless the focal distance is zero
         q_in.big[l]  = (|qmag[NUM_W-1:LIM_BIT+1]) ||
                        (qmag[LIM_BIT] && (|qmag[LIM_BIT-1:0]));
         q_in.qs[l]   = dv_ff[DIV_STEPS].neg[l] ? (QS_W'(0) - qmag[QS_W-1:0])
                                                : qmag[QS_W-1:0];
      end
   end

   // ---------------- focal multiply ----------------
   fprod_type p_ff, p_in;
   logic      p_v_ff;
   logic signed [QS_W-1:0]    qv;
   logic signed [FOCAL_W:0]   fv;
   logic signed [FPROD_W-1:0] pv;

   always_comb begin
      p_in.v    = q_ff.v;
      p_in.zero = q_ff.zero;
      p_in.neg  = q_ff.neg;
      p_in.big  = q_ff.big;
      fv        = $signed({1'b0, focal_ff});
      for (int l = 0; l < LANES; l++) begin
         qv           = $signed(q_ff.qs[l]);
         pv           = qv * fv;
         p_in.prod[l] = pv;
      end
   end

   // ---------------- output ----------------
   logic [COORD_W-1:0] rsp_rot_x_ff, rsp_rot_y_ff, rsp_rot_z_ff;
   logic [COORD_W-1:0] rsp_left_x_ff, rsp_left_y_ff, rsp_right_x_ff;
   logic               rsp_zero_ff, rsp_sat_ff;
   logic [LANES-1:0][COORD_W-1:0] proj;
   logic [LANES-1:0]   proj_ovf;
   sat_type            cp;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         cp = clip_proj(p_ff.prod[l]);
         if (focal_ff == '0) begin
            proj[l]     = '0;
            proj_ovf[l] = 1'b0;
         end else if (p_ff.big[l]) begin
            proj[l]     = p_ff.neg[l] ? SAT_MIN : SAT_MAX;
            proj_ovf[l] = 1'b1;
         end else begin
            proj[l]     = cp.val;
            proj_ovf[l] = cp.ovf;
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff      <= 1'b0;
         a2_v_ff      <= 1'b0;
         m3_v_ff      <= 1'b0;
         a4_v_ff      <= 1'b0;
         m5_v_ff      <= 1'b0;
         a6_v_ff      <= 1'b0;
         t7_v_ff      <= 1'b0;
         dv_v_ff      <= '0;
         q_v_ff       <= 1'b0;
         p_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_v_ff      <= req_valid;
         a2_v_ff      <= m1_v_ff;
         m3_v_ff      <= a2_v_ff;
         a4_v_ff      <= m3_v_ff;
         m5_v_ff      <= a4_v_ff;
         a6_v_ff      <= m5_v_ff;
         t7_v_ff      <= a6_v_ff;
         dv_v_ff      <= {dv_v_ff[DIV_STEPS-1:0], t7_v_ff};
         q_v_ff       <= dv_v_ff[DIV_STEPS];
         p_v_ff       <= q_v_ff;
         rsp_valid_ff <= p_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff <= m1_in;
         a2_ff <= a2_in;
         m3_ff <= m3_in;
         a4_ff <= a4_in;
         m5_ff <= m5_in;
         a6_ff <= a6_in;
         t7_ff <= t7_in;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            dv_ff[k] <= dv_in[k];
         end
         q_ff  <= q_in;
         p_ff  <= p_in;
         rsp_rot_x_ff   <= p_ff.v.x;
         rsp_rot_y_ff   <= p_ff.v.y;
         rsp_rot_z_ff   <= p_ff.v.z;
         rsp_left_x_ff  <= proj[0];
         rsp_left_y_ff  <= proj[1];
         rsp_right_x_ff <= proj[2];
         rsp_zero_ff    <= p_ff.zero;
         rsp_sat_ff     <= p_ff.v.sat | (|proj_ovf);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rot_x          = rsp_rot_x_ff;
   assign rsp_rot_y          = rsp_rot_y_ff;
   assign rsp_rot_z          = rsp_rot_z_ff;
   assign rsp_left_x         = rsp_left_x_ff;
   assign rsp_left_y         = rsp_left_y_ff;
   assign rsp_right_x        = rsp_right_x_ff;
   // both eyes share the vertical coordinate
   assign rsp_right_y        = rsp_left_y_ff;
   assign rsp_depth_was_zero = rsp_zero_ff;
   assign rsp_saturated      = rsp_sat_ff;

   // ---------------- assertions ----------------
   `VRSP_ASSERT_SAME(a_hold_freezes_input, rsp_valid && rsp_stall, req_stall, "input taken while output held")
   `VRSP_ASSERT_NEXT(a_accept_enters, req_valid && !req_stall, m1_v_ff, "accepted word lost at entry")
   `VRSP_ASSERT_SAME(a_valid_from_pipe, $rose(rsp_valid), $past(p_v_ff), "result word without a source")

endmodule
